[rtl/pwm_period_duty_capture_defines.svh]
// assertion helpers for the capture rtl
`ifndef PWM_PERIOD_DUTY_CAPTURE_DEFINES_SVH
`define PWM_PERIOD_DUTY_CAPTURE_DEFINES_SVH

// checked at every clock edge outside reset
`define PDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every clock edge, reset included
`define PDC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/pdc_pkg.sv]
`timescale 1ns / 1ps

package pdc_pkg;

   localparam int STAMP_WIDTH = 16;
   localparam int EXT_WIDTH   = STAMP_WIDTH + 1;

   // operation codes
   localparam logic OP_EDGE     = 1'b0;
   localparam logic OP_OVERFLOW = 1'b1;

   // edge counter codes
   localparam logic [1:0] EDGE_FIRST  = 2'd0;
   localparam logic [1:0] EDGE_SECOND = 2'd1;
   localparam logic [1:0] EDGE_THIRD  = 2'd2;

   typedef struct packed {
      logic                   operation;
      logic [STAMP_WIDTH-1:0] timestamp;
   } item_type;

   typedef struct packed {
      logic                 frame_done;
      logic                 measured_channel;
      logic [EXT_WIDTH-1:0] period_ticks;
      logic [EXT_WIDTH-1:0] high_ticks;
      logic                 negative_flag;
      logic                 expect_falling;
      logic                 next_channel;
   } result_type;

   typedef struct packed {
      logic [1:0]           edge_index;
      logic [EXT_WIDTH-1:0] first_stamp;
      logic [EXT_WIDTH-1:0] second_stamp;
      logic                 overflow_seen;
      logic                 active_channel;
   } state_type;

endpackage

[rtl/pdc_if.sv]
`timescale 1ns / 1ps

interface pdc_req_if;
   import pdc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [STAMP_WIDTH-1:0] timestamp;

   modport source (output valid, output operation, output timestamp, input ready);
   modport sink   (input valid, input operation, input timestamp, output ready);
endinterface

interface pdc_rsp_if;
   import pdc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 frame_done;
   logic                 measured_channel;
   logic [EXT_WIDTH-1:0] period_ticks;
   logic [EXT_WIDTH-1:0] high_ticks;
   logic                 negative_flag;
   logic                 expect_falling;
   logic                 next_channel;

   modport source (
      output valid, output frame_done, output measured_channel, output period_ticks,
      output high_ticks, output negative_flag, output expect_falling,
      output next_channel, input ready
   );
   modport sink (
      input valid, input frame_done, input measured_channel, input period_ticks,
      input high_ticks, input negative_flag, input expect_falling,
      input next_channel, output ready
   );
endinterface

[rtl/pdc_frame_step.sv]
`timescale 1ns / 1ps

module pdc_frame_step (
   input  pdc_pkg::state_type  state_cur,
   input  pdc_pkg::item_type   item,
   output pdc_pkg::state_type  state_next,
   output pdc_pkg::result_type result
);
   import pdc_pkg::*;

   logic [EXT_WIDTH-1:0] stamp_ext;
   logic                 period_neg;
   logic                 high_neg;

   // one wrap added after an overflow: just the carry bit above the stamp
   assign stamp_ext  = {state_cur.overflow_seen, item.timestamp};
   assign period_neg = stamp_ext < state_cur.first_stamp;
   assign high_neg   = state_cur.second_stamp < state_cur.first_stamp;

   always_comb begin
      state_next = state_cur;
      result     = '0;
      if (item.operation == OP_OVERFLOW) begin
         state_next.overflow_seen = 1'b1;
      end else begin
         case (state_cur.edge_index)
            EDGE_FIRST: begin
               state_next.first_stamp = stamp_ext;
               state_next.edge_index  = EDGE_SECOND;
            end
            EDGE_SECOND: begin
               state_next.second_stamp = stamp_ext;
               state_next.edge_index   = EDGE_THIRD;
            end
            default: begin
               result.frame_done       = 1'b1;
               result.measured_channel = state_cur.active_channel;
               result.period_ticks     = period_neg ? '0 : stamp_ext - state_cur.first_stamp;
               result.high_ticks       = high_neg ? '0
                                         : state_cur.second_stamp - state_cur.first_stamp;
               result.negative_flag    = period_neg | high_neg;
               state_next.edge_index     = EDGE_FIRST;
               state_next.overflow_seen  = 1'b0;
               state_next.active_channel = ~state_cur.active_channel;
            end
         endcase
      end
      result.expect_falling = state_next.edge_index == EDGE_SECOND;
      result.next_channel   = state_next.active_channel;
   end

endmodule

[rtl/pwm_period_duty_capture.sv]
`timescale 1ns / 1ps
// PWM period and high-time capture. Each req item is either a captured edge with its
// 16-bit timer stamp or a timer-overflow strobe; every item gives exactly one rsp item.
// A frame is rising, falling, rising edge: on the closing rising edge the rsp carries frame_done,
// the period (third minus first stamp) and the high time (falling minus first stamp),
// both 17 bits, clamped to zero with negative_flag when negative. Stamps taken after an
// overflow in the current frame are extended by one counter wrap (2^16). Every rsp also
// tells which edge polarity and which of the two input channels come next; the channel
// toggles after each completed frame. Throughput is one item per clock while the rsp side
// keeps taking items; a rsp stall holds the flow. An accepted item is stored in the input
// register and then passes the frame update into the result register, which drives the
// rsp item. req ready drops only while both registers hold an item and the rsp item is
// not being taken.

`include "pwm_period_duty_capture_defines.svh"

module pwm_period_duty_capture (
   input logic clock,
   input logic reset,
   pdc_req_if.sink   req_ch,
   pdc_rsp_if.source rsp_ch
);
   import pdc_pkg::*;

   // input register
   logic       s1_valid_ff;
   logic       s1_valid_in;
   item_type   s1_item_ff;
   item_type   s1_item_in;

   // measurement state
   state_type  state_ff;
   state_type  state_in;
   state_type  state_step;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;
   result_type rsp_data_in;
   result_type result_step;

   logic       s1_fire;
   logic       req_fire;

   // the input item moves on once the result register is free or being drained
   assign s1_fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   pdc_frame_step u_step (
      .state_cur  (state_ff),
      .item       (s1_item_ff),
      .state_next (state_step),
      .result     (result_step)
   );

   always_comb begin
      s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
      s1_item_in   = req_fire ? item_type'{operation: req_ch.operation,
                                           timestamp: req_ch.timestamp}
                              : s1_item_ff;
      state_in     = s1_fire ? state_step : state_ff;
      rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_ch.ready);
      rsp_data_in  = s1_fire ? result_step : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
      // payload registers, no reset needed
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   // result port
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.frame_done       = rsp_data_ff.frame_done;
   assign rsp_ch.measured_channel = rsp_data_ff.measured_channel;
   assign rsp_ch.period_ticks     = rsp_data_ff.period_ticks;
   assign rsp_ch.high_ticks       = rsp_data_ff.high_ticks;
   assign rsp_ch.negative_flag    = rsp_data_ff.negative_flag;
   assign rsp_ch.expect_falling   = rsp_data_ff.expect_falling;
   assign rsp_ch.next_channel     = rsp_data_ff.next_channel;

   // reset empties both registers by the next edge
   `PDC_ASSERT_ALWAYS(a_reset_empties, reset |=> !s1_valid_ff && !rsp_valid_ff, "reset left an item")
   // the edge counter never reaches three
   `PDC_ASSERT(a_edge_index_range, state_ff.edge_index != 2'd3, "edge counter hit three")
   // a finished frame expects a rising edge on the other channel next
   `PDC_ASSERT(a_done_next_rising, rsp_valid_ff && rsp_data_ff.frame_done |-> !rsp_data_ff.expect_falling && (rsp_data_ff.next_channel != rsp_data_ff.measured_channel), "frame end did not rearm")
   // measurement fields stay zero outside a finished frame
   `PDC_ASSERT(a_idle_fields_zero, rsp_valid_ff && !rsp_data_ff.frame_done |-> rsp_data_ff.period_ticks == '0 && rsp_data_ff.high_ticks == '0 && !rsp_data_ff.negative_flag && !rsp_data_ff.measured_channel, "fields set without frame")
   // an overflow strobe marks the frame
   `PDC_ASSERT(a_overflow_marks, s1_fire && s1_item_ff.operation == OP_OVERFLOW |=> state_ff.overflow_seen, "overflow not recorded")

endmodule
